[sv/urrb_pkg.sv]
// Shared types and defaults for the serial receive ring buffer.
// Used by urrb_ctrl, urrb_dp and uart_rx_ring_buffer; no dependencies.
package urrb_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int READ_BURST_DEF = 64;

  typedef enum logic [1:0] {
    MODE_RECV    = 2'd0,
    MODE_READ    = 2'd1,
    MODE_CONSUME = 2'd2,
    MODE_PURGE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic latch;
    logic calc_fill;
    logic apply;
    logic calc_span;
    logic issue;
    logic load_byte;
    logic load_single;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  take_zero;
    logic  last_byte;
    logic  out_free;
  } dp_status_t;

endpackage

[sv/urrb_dp.sv]
// Datapath of the receive ring buffer: word store, positions, error count,
// result register. Driven by urrb_ctrl commands; depends on urrb_pkg.
module urrb_dp #(
  parameter int DEPTH      = 256,
  parameter int READ_BURST = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_data,
  input  logic [1:0]           mode,
  input  logic [7:0]           rx_byte,
  input  logic                 line_error,
  input  logic [7:0]           count,
  input  urrb_pkg::dp_cmd_t    cmd,
  output urrb_pkg::dp_status_t status,
  input  logic                 rsp_stall,
  output logic                 rsp_valid,
  output logic [7:0]           data_byte,
  output logic                 data_valid,
  output logic                 last,
  output logic [7:0]           span,
  output logic                 wakeup,
  output logic [31:0]          errors_seen
);
  import urrb_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CW     = (PTR_W > 8) ? PTR_W : 8;
  localparam int SW     = CW + 1;
  localparam int TAKE_W = $clog2(READ_BURST + 1);

  logic [7:0]        ring [DEPTH];
  logic [7:0]        rd_data;

  logic              rx_enable;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  fill;
  logic [PTR_W-1:0]  rd_end;
  logic [TAKE_W-1:0] remaining;
  logic              take_zero;
  logic [31:0]       err_total;
  logic              wake;
  logic [7:0]        span_reg;

  mode_t             item_mode;
  logic [7:0]        item_byte;
  logic              item_err;
  logic [7:0]        item_count;

  logic [SW-1:0]     fill_full;
  logic [SW-1:0]     fill_ext;
  logic [SW-1:0]     cnt_ext;
  logic [SW-1:0]     drop_ext;
  logic [SW-1:0]     take_ext;
  logic [PTR_W-1:0]  rp_drop;
  logic [PTR_W-1:0]  rp_take;
  logic [PTR_W-1:0]  rp_fin;
  logic [PTR_W-1:0]  wp_inc;
  logic [SW-1:0]     span_full;
  logic              store_en;

  function automatic logic [PTR_W-1:0] wrap_sum(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
    return r[PTR_W-1:0];
  endfunction

  assign fill_full = (wp >= rp) ? (SW'(wp) - SW'(rp)) : (SW'(wp) + SW'(DEPTH) - SW'(rp));
  assign fill_ext  = SW'(fill);
  assign cnt_ext   = SW'(item_count);
  assign drop_ext  = (cnt_ext > fill_ext) ? fill_ext : cnt_ext;
  assign take_ext  = (drop_ext > SW'(READ_BURST)) ? SW'(READ_BURST) : drop_ext;
  assign rp_drop   = wrap_sum(SW'(rp) + drop_ext);
  assign rp_take   = wrap_sum(SW'(rp) + take_ext);
  assign wp_inc    = (wp == PTR_W'(DEPTH - 1)) ? '0 : (wp + 1'b1);
  assign store_en  = cmd.apply && (item_mode == MODE_RECV) && rx_enable && !item_err
                     && (fill != PTR_W'(DEPTH - 1));

  assign rp_fin = (item_mode == MODE_READ) ? rd_end : rp;

  always_comb begin
    if (rp_fin == wp) begin
      span_full = '0;
    end else if (rp_fin > wp) begin
      span_full = SW'(DEPTH) - SW'(rp_fin);
    end else begin
      span_full = SW'(wp) - SW'(rp_fin);
    end
  end

  assign status.mode      = item_mode;
  assign status.take_zero = take_zero;
  assign status.last_byte = (remaining == '0);
  assign status.out_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (store_en) begin
      ring[wp] <= item_byte;
    end
    if (cmd.issue) begin
      rd_data <= ring[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_mode  <= mode_t'(mode);
      item_byte  <= rx_byte;
      item_err   <= line_error;
      item_count <= count;
    end
    if (cmd.calc_fill) begin
      fill <= fill_full[PTR_W-1:0];
    end
    if (cmd.calc_span) begin
      span_reg <= (span_full > SW'(255)) ? 8'hFF : span_full[7:0];
    end
    if (cmd.apply) begin
      wake   <= store_en && (fill == '0);
      rd_end <= rp_take;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable <= 1'b0;
      rp        <= '0;
      wp        <= '0;
      err_total <= '0;
      remaining <= '0;
      take_zero <= 1'b0;
    end else begin
      if (cfg_write) begin
        rx_enable <= cfg_data;
      end
      if (cmd.apply) begin
        take_zero <= (take_ext == '0);
        remaining <= take_ext[TAKE_W-1:0];
        case (item_mode)
          MODE_RECV: begin
            if (rx_enable && item_err) begin
              err_total <= err_total + 32'd1;
            end
            if (store_en) begin
              wp <= wp_inc;
            end
          end
          MODE_CONSUME: begin
            rp <= rp_drop;
          end
          MODE_PURGE: begin
            rp <= '0;
            wp <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.issue) begin
        rp        <= (rp == PTR_W'(DEPTH - 1)) ? '0 : (rp + 1'b1);
        remaining <= remaining - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_byte || cmd.load_single) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte || cmd.load_single) begin
      data_byte   <= cmd.load_byte ? rd_data : 8'd0;
      data_valid  <= cmd.load_byte;
      last        <= cmd.load_byte ? status.last_byte : 1'b1;
      span        <= span_reg;
      wakeup      <= cmd.load_single && wake;
      errors_seen <= err_total;
    end
  end

endmodule

[sv/urrb_ctrl.sv]
// Controller of the receive ring buffer: sequences decode, update, span
// and the read burst. Drives urrb_dp through dp_cmd_t; depends on urrb_pkg.
module urrb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  urrb_pkg::dp_status_t status,
  output urrb_pkg::dp_cmd_t    cmd
);
  import urrb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_APPLY,
    ST_SPAN,
    ST_RESULT,
    ST_ISSUE,
    ST_READ
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.latch = req_valid;
        if (req_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.calc_fill = 1'b1;
        state_next    = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_SPAN;
      end
      ST_SPAN: begin
        cmd.calc_span = 1'b1;
        if ((status.mode == MODE_READ) && !status.take_zero) begin
          state_next = ST_ISSUE;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.load_single = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_ISSUE: begin
        cmd.issue  = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        if (status.out_free) begin
          cmd.load_byte = 1'b1;
          if (status.last_byte) begin
            state_next = ST_IDLE;
          end else begin
            cmd.issue = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/uart_rx_ring_buffer.sv]
// Top level of the serial receive ring buffer.
// Joins urrb_ctrl and urrb_dp; depends on urrb_pkg.
//
// Request channel (req_valid/req_stall) takes one word: mode, rx_byte,
// line_error, count. Response channel (rsp_valid/rsp_stall) returns one word
// for modes 0, 2 and 3 and for an empty read, or one word per byte read in
// mode 1, the final one marked by last. cfg_write/cfg_data set rx_enable.
// One request is worked at a time. Each request passes the decode, apply,
// span and result states (a read with bytes: span, issue and read states)
// before the next accept; the read bytes leave one per cycle while the
// response is not stalled, paced by the single read port of the store.
// A stalled response holds in the output register; the block waits for it
// to drain before loading the next word. Reset empties the ring, clears the
// error count and disables reception; store contents are not cleared.
module uart_rx_ring_buffer #(
  parameter int DEPTH      = urrb_pkg::DEPTH_DEF,
  parameter int READ_BURST = urrb_pkg::READ_BURST_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  input  logic        line_error,
  input  logic [7:0]  count,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  data_byte,
  output logic        data_valid,
  output logic        last,
  output logic [7:0]  span,
  output logic        wakeup,
  output logic [31:0] errors_seen
);
  import urrb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  urrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  urrb_dp #(
    .DEPTH      (DEPTH),
    .READ_BURST (READ_BURST)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .rx_byte     (rx_byte),
    .line_error  (line_error),
    .count       (count),
    .cmd         (cmd),
    .status      (status),
    .rsp_stall   (rsp_stall),
    .rsp_valid   (rsp_valid),
    .data_byte   (data_byte),
    .data_valid  (data_valid),
    .last        (last),
    .span        (span),
    .wakeup      (wakeup),
    .errors_seen (errors_seen)
  );

endmodule

[sim/uart_rx_ring_buffer_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for uart_rx_ring_buffer: directed, fill/wrap and random request words.
// Depends on urrb_pkg and the uart_rx_ring_buffer RTL; carries its own ring predictor.
module uart_rx_ring_buffer_test;
  import urrb_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int BURST       = READ_BURST_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        last;
    logic [7:0]  span;
    logic        wakeup;
    logic [31:0] errors_seen;
  } rx_result_t;

  logic        clk;
  logic        rst         = 1'b1;
  logic        cfg_write   = 1'b0;
  logic        cfg_data    = 1'b0;
  logic        req_valid   = 1'b0;
  logic        req_stall;
  logic [1:0]  mode        = 2'd0;
  logic [7:0]  rx_byte     = 8'h00;
  logic        line_error  = 1'b0;
  logic [7:0]  count       = 8'h00;
  logic        rsp_valid;
  logic        rsp_stall   = 1'b0;
  logic [7:0]  data_byte;
  logic        data_valid;
  logic        last;
  logic [7:0]  span;
  logic        wakeup;
  logic [31:0] errors_seen;

  bit [7:0]    ring_copy [DEPTH];
  int          rd_pos      = 0;
  int          wr_pos      = 0;
  logic [31:0] line_errors = 32'd0;
  logic        rx_on       = 1'b0;

  rx_result_t  pending_results [$];
  int          idle_pct      = 35;
  int          holdoff_left  = 0;
  int          cycle_count   = 0;
  int          fail_count    = 0;
  int          words_sent    = 0;
  int          results_seen  = 0;
  int          bytes_stored  = 0;
  int          bytes_dropped = 0;
  int          bytes_read    = 0;
  int          wakeups       = 0;

  uart_rx_ring_buffer DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .mode(mode), .rx_byte(rx_byte),
    .line_error(line_error), .count(count), .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall), .data_byte(data_byte), .data_valid(data_valid),
    .last(last), .span(span), .wakeup(wakeup), .errors_seen(errors_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("** uart_rx_ring_buffer: FAILED **");
      $finish;
    end
  end

  function automatic void ring_apply(mode_t op, logic [7:0] data, logic err, logic [7:0] num);
    int         fill;
    int         take;
    int         sp;
    logic       woke;
    logic [7:0] read_bytes [$];
    woke = 1'b0;
    fill = (wr_pos + DEPTH - rd_pos) % DEPTH;
    case (op)
      MODE_RECV: begin
        if (rx_on) begin
          if (err) begin
            line_errors = line_errors + 32'd1;
          end else if (fill < DEPTH - 1) begin
            ring_copy[wr_pos] = data;
            wr_pos = (wr_pos + 1) % DEPTH;
            woke = (fill == 0);
            bytes_stored++;
          end else begin
            bytes_dropped++;
          end
        end
      end
      MODE_READ: begin
        take = num;
        if (take > fill) take = fill;
        if (take > BURST) take = BURST;
        for (int k = 0; k < take; k++) begin
          read_bytes.push_back(ring_copy[rd_pos]);
          rd_pos = (rd_pos + 1) % DEPTH;
        end
      end
      MODE_CONSUME: begin
        rd_pos = (rd_pos + ((num > fill) ? fill : num)) % DEPTH;
      end
      default: begin
        rd_pos = 0;
        wr_pos = 0;
      end
    endcase
    if (rd_pos == wr_pos) sp = 0;
    else if (rd_pos > wr_pos) sp = DEPTH - rd_pos;
    else sp = wr_pos - rd_pos;
    if (sp > 255) sp = 255;
    if (woke) wakeups++;
    if (read_bytes.size() == 0) begin
      pending_results.push_back({8'h00, 1'b0, 1'b1, 8'(sp), woke, line_errors});
    end else begin
      bytes_read += read_bytes.size();
      foreach (read_bytes[k])
        pending_results.push_back({read_bytes[k], 1'b1, 1'(k == read_bytes.size() - 1),
                                   8'(sp), 1'b0, line_errors});
    end
  endfunction

  function automatic void check_result();
    rx_result_t want;
    logic       bad;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("unexpected result: byte %h valid %b last %b span %0d wake %b errors %0d",
                 data_byte, data_valid, last, span, wakeup, errors_seen);
      return;
    end
    want = pending_results.pop_front();
    results_seen++;
    bad = (data_byte !== want.data_byte) || (data_valid !== want.data_valid) ||
          (last !== want.last) || (span !== want.span) ||
          (wakeup !== want.wakeup) || (errors_seen !== want.errors_seen);
    if (bad) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("mismatch on result %0d (expected / actual):", results_seen);
        $display("  byte %h/%h valid %b/%b last %b/%b span %0d/%0d wake %b/%b errors %0d/%0d",
                 want.data_byte, data_byte, want.data_valid, data_valid, want.last, last,
                 want.span, span, want.wakeup, wakeup, want.errors_seen, errors_seen);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) check_result();
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic send_word(mode_t op, logic [7:0] data, logic err, logic [7:0] num);
    int gap;
    gap = 0;
    while (($urandom_range(99) < idle_pct) && (gap < 12)) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    mode       <= op;
    rx_byte    <= data;
    line_error <= err;
    count      <= num;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    ring_apply(op, data, err, num);
    words_sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_rx_enable(logic value);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    rx_on = value;
    cfg_write <= 1'b0;
  endtask

  task automatic random_words(int n);
    int         pick;
    mode_t      op;
    logic [7:0] num;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 55) op = MODE_RECV;
      else if (pick < 77) op = MODE_READ;
      else if (pick < 96) op = MODE_CONSUME;
      else op = MODE_PURGE;
      num = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
      send_word(op, 8'($urandom_range(255)), ($urandom_range(99) < 8), num);
    end
  endtask

  task automatic test_after_reset();
    send_word(MODE_RECV, 8'h3C, 1'b0, 8'h00);
    send_word(MODE_RECV, 8'hC3, 1'b1, 8'h00);
    send_word(MODE_READ, 8'h00, 1'b0, 8'hFF);
    send_word(MODE_CONSUME, 8'h00, 1'b0, 8'h05);
    send_word(MODE_PURGE, 8'h00, 1'b0, 8'h00);
  endtask

  task automatic test_directed();
    write_rx_enable(1'b1);
    send_word(MODE_RECV, 8'h00, 1'b0, 8'h00);
    send_word(MODE_RECV, 8'hFF, 1'b0, 8'hFF);
    send_word(MODE_RECV, 8'hA5, 1'b1, 8'h00);
    send_word(MODE_RECV, 8'h5A, 1'b0, 8'h00);
    send_word(MODE_READ, 8'h00, 1'b0, 8'h00);
    send_word(MODE_READ, 8'h00, 1'b0, 8'h01);
    send_word(MODE_READ, 8'h00, 1'b0, 8'hFF);
    send_word(MODE_READ, 8'h00, 1'b0, 8'h0A);
    send_word(MODE_RECV, 8'h80, 1'b0, 8'h00);
    send_word(MODE_RECV, 8'h01, 1'b0, 8'h00);
    send_word(MODE_RECV, 8'h7F, 1'b0, 8'h00);
    send_word(MODE_CONSUME, 8'h00, 1'b0, 8'hFF);
    send_word(MODE_RECV, 8'h33, 1'b0, 8'h00);
    send_word(MODE_PURGE, 8'h00, 1'b0, 8'h00);
    send_word(MODE_CONSUME, 8'h00, 1'b0, 8'h00);
    send_word(MODE_CONSUME, 8'h00, 1'b0, 8'h01);
    send_word(MODE_RECV, 8'hFF, 1'b1, 8'hFF);
    write_rx_enable(1'b0);
    send_word(MODE_RECV, 8'h44, 1'b1, 8'h00);
    send_word(MODE_RECV, 8'h44, 1'b0, 8'h00);
  endtask

  task automatic test_full_ring();
    write_rx_enable(1'b1);
    send_word(MODE_PURGE, 8'h00, 1'b0, 8'h00);
    holdoff_left = 300;
    idle_pct = 0;
    repeat (DEPTH) send_word(MODE_RECV, 8'($urandom_range(255)), 1'b0, 8'h00);
    idle_pct = 35;
    send_word(MODE_READ, 8'h00, 1'b0, 8'hFF);
    send_word(MODE_READ, 8'h00, 1'b0, 8'd64);
    repeat (2) send_word(MODE_RECV, 8'($urandom_range(255)), 1'b0, 8'h00);
    send_word(MODE_CONSUME, 8'h00, 1'b0, 8'd100);
    send_word(MODE_READ, 8'h00, 1'b0, 8'hFF);
    send_word(MODE_READ, 8'h00, 1'b0, 8'd65);
    send_word(MODE_CONSUME, 8'h00, 1'b0, 8'hFF);
  endtask

  task automatic test_random();
    write_rx_enable(1'b1);
    idle_pct = 35;
    random_words(8);
    write_rx_enable(1'b0);
    random_words(2);
    write_rx_enable(1'b1);
    random_words(8);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_directed();
    test_full_ring();
    test_random();
    wait_drained();
    repeat (12) @(posedge clk);
    $display("Sent %0d request words and checked %0d results with random stalls on both sides.",
             words_sent, results_seen);
    $display("Ring: %0d bytes stored, %0d read, %0d dropped when full, %0d wakeups, %0d line errors.",
             bytes_stored, bytes_read, bytes_dropped, wakeups, line_errors);
    if (fail_count == 0) begin
      $display("** uart_rx_ring_buffer: PASSED **");
    end else begin
      $display("%0d failures", fail_count);
      $display("** uart_rx_ring_buffer: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/urrb_pkg.sv
sv/urrb_dp.sv
sv/urrb_ctrl.sv
sv/uart_rx_ring_buffer.sv
sim/uart_rx_ring_buffer_test.sv
